// File: rtl/vlfr_pkg.sv
// ----------------------------------------------------------------------------
// vlfr_pkg
// Shared types and constants of the vision link frame receiver.
// ----------------------------------------------------------------------------
package vlfr_pkg;

  localparam logic [7:0]  HEADER_BYTE  = 8'hcd;
  localparam logic [7:0]  TRAILER_BYTE = 8'hdc;
  localparam logic [19:0] FOLD_AT      = 20'd1000000;
  localparam logic [19:0] FOLD_TO      = 20'd500;

  localparam int TICKS_W = 20;
  localparam int PAIRS_W = 4;
  localparam int OUT_W   = 96;

  localparam logic [TICKS_W-1:0] OFFLINE_RST = 20'd500;
  localparam logic [PAIRS_W-1:0] STALE_RST   = 4'd7;

  // register index (paddr[2])
  localparam logic REG_OFFLINE = 1'b0;
  localparam logic REG_STALE   = 1'b1;

  // item kind on in_tuser[0]
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_TICK_UPD,
    S_TICK_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic cap_item;
    logic byte_step;
    logic tick_upd;
    logic tick_chk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/vlfr_ctrl.sv
// ----------------------------------------------------------------------------
// vlfr_ctrl
// Sequencer: takes one beat, steps the datapath, hands the result over.
// ----------------------------------------------------------------------------
module vlfr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  vlfr_pkg::sts_t  sts,
  output vlfr_pkg::cmd_t  cmd
);

  vlfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vlfr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vlfr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == vlfr_pkg::ACT_TICK) ? vlfr_pkg::S_TICK_UPD
                                                        : vlfr_pkg::S_BYTE;
        end
      end
      vlfr_pkg::S_BYTE:     state_nxt = vlfr_pkg::S_DONE;
      vlfr_pkg::S_TICK_UPD: state_nxt = vlfr_pkg::S_TICK_CHK;
      vlfr_pkg::S_TICK_CHK: state_nxt = vlfr_pkg::S_DONE;
      vlfr_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt = vlfr_pkg::S_IDLE;
        end
      end
      default:              state_nxt = vlfr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vlfr_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.cap_item = in_valid;
      end
      vlfr_pkg::S_BYTE:     cmd.byte_step = 1'b1;
      vlfr_pkg::S_TICK_UPD: cmd.tick_upd  = 1'b1;
      vlfr_pkg::S_TICK_CHK: cmd.tick_chk  = 1'b1;
      vlfr_pkg::S_DONE:     cmd.load_out  = sts.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

// File: rtl/vlfr_dp.sv
// ----------------------------------------------------------------------------
// vlfr_dp
// Datapath: frame store, latched words, link monitor, pitch history, result.
// ----------------------------------------------------------------------------
module vlfr_dp #(
  parameter int FRAME_LENGTH  = 15,
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vlfr_pkg::cmd_t                    cmd,
  output vlfr_pkg::sts_t                    sts,
  input  logic [7:0]                        in_byte,
  input  logic                              in_start,
  input  logic [vlfr_pkg::TICKS_W-1:0]      offline_ticks,
  input  logic [vlfr_pkg::PAIRS_W-1:0]      stale_pairs,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vlfr_pkg::OUT_W-1:0]        out_data,
  output logic                              out_accepted
);

  localparam int STORE_D = FRAME_LENGTH - 1;
  localparam int IDX_W   = $clog2(STORE_D);
  localparam int CNT_W   = $clog2(FRAME_LENGTH + 1);
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int PCNT_W  = $clog2(HISTORY_DEPTH);

  // captured beat
  logic [7:0]               byte_r;
  logic                     start_r;

  logic [7:0]               store_r [STORE_D];
  logic [CNT_W-1:0]         cnt_r;
  logic [31:0]              pitch_r, yaw_r;
  logic [4:0]               status_r;
  logic                     link_r, link_prev_r, acc_r;
  logic [vlfr_pkg::TICKS_W-1:0] to_r;
  logic [31:0]              hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0]        slot_r;
  logic [PCNT_W-1:0]        pairs_r;

  logic [vlfr_pkg::OUT_W-1:0] out_data_r;
  logic                       out_acc_r, out_valid_r;

  logic [CNT_W-1:0]         cnt_eff;
  logic                     is_last, good_frame;
  logic [vlfr_pkg::TICKS_W-1:0] to_inc, to_nxt;
  logic [PCNT_W-1:0]        pairs_cnt;
  logic [vlfr_pkg::PAIRS_W-1:0] pairs_ext, last_ext;

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      byte_r  <= in_byte;
      start_r <= in_start;
    end
  end

  // --- byte path ---
  assign cnt_eff    = start_r ? '0 : cnt_r;
  assign is_last    = (cnt_eff == CNT_W'(FRAME_LENGTH - 1));
  assign good_frame = is_last && (store_r[0] == vlfr_pkg::HEADER_BYTE) &&
                      (byte_r == vlfr_pkg::TRAILER_BYTE);

  always_ff @(posedge clk) begin
    if (cmd.byte_step && (cnt_eff < CNT_W'(FRAME_LENGTH - 1))) begin
      store_r[cnt_eff[IDX_W-1:0]] <= byte_r;
    end
  end

  // --- tick path ---
  assign to_inc = to_r + 1'b1;
  always_comb begin
    if (link_r) begin
      to_nxt = '0;
    end else if (to_inc == vlfr_pkg::FOLD_AT) begin
      to_nxt = vlfr_pkg::FOLD_TO;
    end else begin
      to_nxt = to_inc;
    end
  end

  always_comb begin
    pairs_cnt = '0;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      if (hist_r[i] == hist_r[i-1]) begin
        pairs_cnt = pairs_cnt + PCNT_W'(1);
      end
    end
  end
  assign pairs_ext = vlfr_pkg::PAIRS_W'(pairs_cnt);
  assign last_ext  = vlfr_pkg::PAIRS_W'(pairs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      status_r    <= '0;
      link_r      <= 1'b0;
      link_prev_r <= 1'b0;
      acc_r       <= 1'b0;
      to_r        <= '0;
      slot_r      <= '0;
      pairs_r     <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cmd.byte_step) begin
        acc_r <= good_frame;
        if (cnt_eff < CNT_W'(FRAME_LENGTH - 1)) begin
          cnt_r <= cnt_eff + 1'b1;
        end else begin
          cnt_r <= CNT_W'(FRAME_LENGTH);
        end
        if (good_frame) begin
          pitch_r  <= {store_r[4], store_r[3], store_r[2], store_r[1]};
          yaw_r    <= {store_r[8], store_r[7], store_r[6], store_r[5]};
          status_r <= store_r[9][4:0];
          link_r   <= 1'b1;
        end
      end
      if (cmd.tick_upd) begin
        acc_r          <= 1'b0;
        link_prev_r    <= link_r;
        to_r           <= to_nxt;
        hist_r[slot_r] <= pitch_r;
        slot_r         <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : slot_r + 1'b1;
      end
      if (cmd.tick_chk) begin
        pairs_r <= pairs_cnt;
        if ((to_r >= offline_ticks) || (pairs_ext >= stale_pairs)) begin
          link_r <= 1'b0;
        end
      end
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_acc_r  <= acc_r;
      out_data_r <= {1'b0, last_ext, to_r, link_prev_r, link_r,
                     status_r[2:0], status_r[3], status_r[4], yaw_r, pitch_r};
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_accepted  = out_acc_r;

endmodule

// File: rtl/vision_link_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// vision_link_frame_receiver_top
// Serial vision link frame receiver with link health monitor.
// ----------------------------------------------------------------------------
// Each input beat is either a received byte or a monitor tick (in_tuser[0]).
// Bytes build a FRAME_LENGTH-byte frame starting at the byte flagged by
// in_tuser[1]; a frame with header 0xcd and trailer 0xdc latches pitch, yaw
// (little-endian words from bytes 1..4 and 5..8) and the status byte 9, and
// raises link_ok. A tick copies link_ok to link_ok_before, counts missed ticks
// while the link is down (folding 1000000 back to 500), pushes pitch into a
// HISTORY_DEPTH-slot ring and counts equal adjacent slots; the link drops when
// the missed count reaches offline_ticks or the equal pairs reach stale_pairs.
// Every beat returns one result beat with the full status. Each beat runs
// through the sequencer steps in order: capture, then the byte step for a
// byte or update and history compare for a tick, then the load into the
// output register. One item is in work at a time, and the next beat is
// taken while the previous result still waits in the output register.
// An output stall holds the load step only when a second result is ready
// before the first is taken. Registers: 0x0 offline_ticks (reset 500), 0x4
// stale_pairs (reset 7); write them only while the block is idle.
// ----------------------------------------------------------------------------
module vision_link_frame_receiver_top #(
  parameter int FRAME_LENGTH  = 15,
  parameter int HISTORY_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic [1:0]  in_tuser,    // [0] action, [1] frame_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] pitch_bits, [63:32] yaw_bits, [64] target_seen, [65] fire_request,
  // [68:66] track_mode, [69] link_ok, [70] link_ok_before,
  // [90:71] missed_ticks, [94:91] equal_pairs, [95] zero
  output logic [95:0] out_tdata,
  output logic        out_tuser,   // [0] frame_accepted
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  vlfr_pkg::cmd_t cmd;
  vlfr_pkg::sts_t sts;

  logic [vlfr_pkg::TICKS_W-1:0] offline_r;
  logic [vlfr_pkg::PAIRS_W-1:0] stale_r;
  logic                         cfg_wr;

  // APB register file, zero wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_r <= vlfr_pkg::OFFLINE_RST;
      stale_r   <= vlfr_pkg::STALE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        vlfr_pkg::REG_OFFLINE: offline_r <= cfg_pwdata[vlfr_pkg::TICKS_W-1:0];
        vlfr_pkg::REG_STALE:   stale_r   <= cfg_pwdata[vlfr_pkg::PAIRS_W-1:0];
        default:               offline_r <= offline_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      vlfr_pkg::REG_OFFLINE: cfg_prdata = 32'(offline_r);
      vlfr_pkg::REG_STALE:   cfg_prdata = 32'(stale_r);
      default:               cfg_prdata = '0;
    endcase
  end

  vlfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlfr_dp #(
    .FRAME_LENGTH  (FRAME_LENGTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_byte       (in_tdata),
    .in_start      (in_tuser[1]),
    .offline_ticks (offline_r),
    .stale_pairs   (stale_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata),
    .out_accepted  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // a freshly accepted frame always shows the link up
  a_acc_link: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[69])
    else $error("frame accepted without link up");

  // missed tick count never reaches the fold point
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[90:71] < vlfr_pkg::FOLD_AT))
    else $error("missed tick count out of range");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("beat taken while busy");

  // equal pairs never exceed the ring's adjacent slot count
  a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[94:91] <= 4'(HISTORY_DEPTH - 1)))
    else $error("equal pair count out of range");

endmodule

// File: tb/tb_vision_link_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vision_link_frame_receiver_top
// Self-checking bench for the vision link frame receiver.
// ----------------------------------------------------------------------------
// Drives byte and tick beats into the input stream, tracks the receiver's
// frame, latch, link and pitch history state in a local predictor, and checks
// every result beat field by field in order. Directed tests cover the reset
// state, latched fields, broken frames, the timeout and stale-data link drops;
// a random test then runs mostly well-formed frames mixed with ticks, cut-off
// frames and noise under several register settings, with random sender gaps
// and result-side stalls. Registers are written over APB and read back.
// ----------------------------------------------------------------------------
module tb_vision_link_frame_receiver_top;

  localparam int FRAME_LEN      = 15;
  localparam int HIST_DEPTH     = 10;
  localparam int RANDOM_BEATS   = 224;   // live random beats, ignored bytes not counted
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat and no APB traffic
  localparam int TAIL_CYCLES    = 20;    // generous margin after the drain

  // result-side ready styles
  typedef enum logic [1:0] {
    RDY_FREE,
    RDY_CHOPPY,
    RDY_STARVED
  } ready_style_t;

  // one result beat, unpacked
  typedef struct packed {
    logic        frame_ok;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic        target;
    logic        fire;
    logic [2:0]  mode;
    logic        link;
    logic        link_prev;
    logic [19:0] missed;
    logic [3:0]  pairs;
  } link_status_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser    = '0;   // [0] action, [1] frame_start
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;          // pitch, yaw, status, link, counters (see DUT)
  logic        out_tuser;          // [0] frame_accepted
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  vision_link_frame_receiver_top #(
    .FRAME_LENGTH (FRAME_LEN),
    .HISTORY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow copy of registers, frame assembly, latches, link
  // monitor and pitch history ring.
  // --------------------------------------------------------------------------
  logic [19:0]  cfg_offline = vlfr_pkg::OFFLINE_RST;
  logic [3:0]   cfg_stale   = vlfr_pkg::STALE_RST;

  int unsigned  rx_pos;            // next frame position; FRAME_LEN = frame done
  logic [7:0]   rx_buf [16];
  logic [31:0]  lat_pitch;
  logic [31:0]  lat_yaw;
  logic [4:0]   lat_status;
  logic         link_up;
  logic         link_up_prev;
  int unsigned  miss_cnt;
  logic [31:0]  pitch_ring [HIST_DEPTH];
  int unsigned  ring_wr;
  logic [3:0]   ring_pairs;

  link_status_t status_due_q [$];  // expected results, oldest first

  // run statistics
  int fail_count;
  int beats_sent;
  int live_beats;
  int results_seen;
  int frames_taken;
  int link_drops;
  int settings_used;

  int unsigned  burst_left;
  logic [31:0]  pitch_pool [4];    // reused pitch values so the history goes stale

  // Advance the shadow state by one beat and return the status the DUT must
  // report. Bytes after a finished frame with no start flag are skipped.
  function automatic link_status_t predict_link_status(input logic act, input logic [7:0] dat,
                                                       input logic sof, output bit skipped);
    link_status_t s;
    int unsigned  pairs;
    logic         done;
    done    = 1'b0;
    skipped = 1'b0;
    if (act == vlfr_pkg::ACT_BYTE) begin
      if (sof) rx_pos = 0;
      if (rx_pos >= FRAME_LEN) begin
        skipped = 1'b1;
      end else if (rx_pos < FRAME_LEN - 1) begin
        rx_buf[rx_pos] = dat;
        rx_pos++;
      end else begin
        // last byte: only a matching header and trailer latch anything
        rx_pos = FRAME_LEN;
        if (rx_buf[0] == vlfr_pkg::HEADER_BYTE && dat == vlfr_pkg::TRAILER_BYTE) begin
          lat_pitch  = {rx_buf[4], rx_buf[3], rx_buf[2], rx_buf[1]};
          lat_yaw    = {rx_buf[8], rx_buf[7], rx_buf[6], rx_buf[5]};
          lat_status = rx_buf[9][4:0];
          link_up    = 1'b1;
          done       = 1'b1;
          frames_taken++;
        end
      end
    end else begin
      link_up_prev = link_up;
      if (!link_up) begin
        miss_cnt++;
        if (miss_cnt >= vlfr_pkg::FOLD_AT) miss_cnt = vlfr_pkg::FOLD_TO;
      end else begin
        miss_cnt = 0;
      end
      pitch_ring[ring_wr] = lat_pitch;
      ring_wr = (ring_wr + 1 == HIST_DEPTH) ? 0 : ring_wr + 1;
      // adjacent slots only, no wrap from last slot to first
      pairs = 0;
      for (int i = 1; i < HIST_DEPTH; i++)
        if (pitch_ring[i] == pitch_ring[i-1]) pairs++;
      ring_pairs = pairs[3:0];
      if (miss_cnt >= cfg_offline || pairs >= cfg_stale) begin
        if (link_up) link_drops++;
        link_up = 1'b0;
      end
    end
    s.frame_ok  = done;
    s.pitch     = lat_pitch;
    s.yaw       = lat_yaw;
    s.target    = lat_status[4];
    s.fire      = lat_status[3];
    s.mode      = lat_status[2:0];
    s.link      = link_up;
    s.link_prev = link_up_prev;
    s.missed    = miss_cnt[19:0];
    s.pairs     = ring_pairs;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    link_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (status_due_q.size() == 0) begin
        $error("result beat with no expectation pending: tdata 0x%0h", out_tdata);
        fail_count++;
      end else begin
        want = status_due_q.pop_front();
        check_field("frame_accepted", 32'(want.frame_ok),  32'(out_tuser));
        check_field("pitch_bits",     want.pitch,          out_tdata[31:0]);
        check_field("yaw_bits",       want.yaw,            out_tdata[63:32]);
        check_field("target_seen",    32'(want.target),    32'(out_tdata[64]));
        check_field("fire_request",   32'(want.fire),      32'(out_tdata[65]));
        check_field("track_mode",     32'(want.mode),      32'(out_tdata[68:66]));
        check_field("link_ok",        32'(want.link),      32'(out_tdata[69]));
        check_field("link_ok_before", 32'(want.link_prev), 32'(out_tdata[70]));
        check_field("missed_ticks",   32'(want.missed),    32'(out_tdata[90:71]));
        check_field("equal_pairs",    32'(want.pairs),     32'(out_tdata[94:91]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side ready: segments of free flow, random chatter and long starves.
  // --------------------------------------------------------------------------
  ready_style_t ready_style = RDY_FREE;
  int unsigned  ready_seg_left;

  always @(negedge clk) begin
    if (ready_seg_left == 0) begin
      ready_style    = ready_style_t'($urandom_range(0, 2));
      ready_seg_left = $urandom_range(4, 48);
    end
    ready_seg_left--;
    case (ready_style)
      RDY_FREE:    out_tready = 1'b1;
      RDY_CHOPPY:  out_tready = 1'($urandom_range(0, 1));
      default:     out_tready = ($urandom_range(0, 5) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: nothing moving for too long ends the run.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, status_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one beat per call, changes at falling edge, accepted at a rising
  // edge with tvalid and tready high. Bursts of random length, random gaps.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic act, input logic [7:0] dat, input logic sof);
    link_status_t want;
    bit           skipped;
    int unsigned  gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = dat;
    in_tuser  = {sof, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_link_status(act, dat, sof, skipped);
    status_due_q.push_back(want);
    beats_sent++;
    if (!skipped) live_beats++;
    // end of burst: drop valid for a while; otherwise the next beat follows
    // straight on with valid held high
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick();
    send_beat(vlfr_pkg::ACT_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Full frame: header, pitch and yaw little-endian, status, filler, trailer.
  // tick_pct > 0 slips ticks in between the bytes.
  task automatic send_frame(input logic [7:0] hdr, input logic [31:0] pitch,
                            input logic [31:0] yaw, input logic [7:0] status,
                            input logic [7:0] trl, input logic sof, input int tick_pct);
    logic [7:0] b;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == 0)                b = hdr;
      else if (i <= 4)           b = pitch[8*(i-1) +: 8];
      else if (i <= 8)           b = yaw[8*(i-5) +: 8];
      else if (i == 9)           b = status;
      else if (i == FRAME_LEN-1) b = trl;
      else                       b = 8'($urandom);
      if (tick_pct > 0 && i > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      send_beat(vlfr_pkg::ACT_BYTE, b, (i == 0) ? sof : 1'b0);
    end
  endtask

  // Quiesce input and wait until every expected result has come back.
  // Each beat gives exactly one result, so an empty queue means idle.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (status_due_q.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB: setup cycle, then access cycle; pready is sampled at the rising edge.
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic reg_check(input logic idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    check_field((idx == vlfr_pkg::REG_OFFLINE) ? "offline_ticks readback"
                                               : "stale_pairs readback",
                want, rd);
  endtask

  task automatic set_regs(input logic [19:0] offline, input logic [3:0] stale);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, vlfr_pkg::REG_OFFLINE, {12'd0, offline}, rd);
    apb_xfer(1'b1, vlfr_pkg::REG_STALE, {28'd0, stale}, rd);
    cfg_offline = offline;
    cfg_stale   = stale;
    reg_check(vlfr_pkg::REG_OFFLINE, {12'd0, offline});
    reg_check(vlfr_pkg::REG_STALE, {28'd0, stale});
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults, tick on an all-zero history, and a frame whose first
  // byte carries no start flag (byte 0 anyway after reset). Bytes after the
  // trailer without a start flag must be ignored.
  task automatic test_reset_state();
    reg_check(vlfr_pkg::REG_OFFLINE, {12'd0, vlfr_pkg::OFFLINE_RST});
    reg_check(vlfr_pkg::REG_STALE, {28'd0, vlfr_pkg::STALE_RST});
    send_beat(vlfr_pkg::ACT_TICK, 8'h00, 1'b0);
    send_frame(vlfr_pkg::HEADER_BYTE, 32'hffff_ffff, 32'h0000_0000, 8'hff,
               vlfr_pkg::TRAILER_BYTE, 1'b0, 0);
    send_beat(vlfr_pkg::ACT_BYTE, 8'hff, 1'b0);
    send_beat(vlfr_pkg::ACT_BYTE, vlfr_pkg::HEADER_BYTE, 1'b0);
    send_beat(vlfr_pkg::ACT_TICK, 8'hff, 1'b1);
  endtask

  // Latched words and status bits at their extremes; status bits 7..5 dropped.
  task automatic test_frame_fields();
    send_frame(vlfr_pkg::HEADER_BYTE, 32'h0000_0000, 32'hffff_ffff, 8'he0,
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    send_frame(vlfr_pkg::HEADER_BYTE, 32'h8000_0001, 32'h7fff_fffe, 8'h15,
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    send_tick();
  endtask

  // Bad header, bad trailer, restart in mid-frame, ticks inside a frame.
  task automatic test_bad_frames();
    send_frame(8'hcc, $urandom, $urandom, 8'($urandom), vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    send_frame(vlfr_pkg::HEADER_BYTE, $urandom, $urandom, 8'($urandom), 8'hdd, 1'b1, 0);
    send_beat(vlfr_pkg::ACT_BYTE, vlfr_pkg::HEADER_BYTE, 1'b1);
    repeat (5) send_beat(vlfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
    send_frame(vlfr_pkg::HEADER_BYTE, $urandom, $urandom, 8'($urandom),
               vlfr_pkg::TRAILER_BYTE, 1'b1, 30);
  endtask

  // offline_ticks 0 drops the link at once; missed ticks then count up.
  // A frame with a short timeout keeps the link up as the count clears.
  task automatic test_link_timeout();
    set_regs(20'd0, 4'd15);
    repeat (4) send_tick();
    set_regs(20'd3, 4'd15);
    send_frame(vlfr_pkg::HEADER_BYTE, $urandom, $urandom, 8'($urandom),
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    repeat (5) send_tick();
  endtask

  // Constant pitch fills the history until the stale limit drops the link;
  // then the smallest and zero stale limits.
  task automatic test_stale_history();
    logic [31:0] p;
    p = $urandom;
    set_regs(20'd999999, 4'd9);
    send_frame(vlfr_pkg::HEADER_BYTE, p, $urandom, 8'($urandom),
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    repeat (11) send_tick();
    set_regs(20'd999999, 4'd1);
    send_frame(vlfr_pkg::HEADER_BYTE, ~p, $urandom, 8'($urandom),
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    repeat (2) send_tick();
    set_regs(20'd999999, 4'd0);
    send_frame(vlfr_pkg::HEADER_BYTE, $urandom, $urandom, 8'($urandom),
               vlfr_pkg::TRAILER_BYTE, 1'b1, 0);
    send_tick();
  endtask

  // Mostly well-formed frames with random content, pitch often repeated,
  // mixed with tick runs, cut-off frames and raw noise, over several
  // register settings including both extremes.
  task automatic test_random_traffic();
    logic [19:0] offline_plan [8];
    logic [3:0]  stale_plan [8];
    int          quota;
    int          start_live;
    int          pick;
    logic [31:0] p;
    offline_plan = '{20'd500, 20'd1, 20'd999999, 20'd0, 20'd3, 20'hfffff, 20'd2, 20'd40};
    stale_plan   = '{4'd7, 4'd1, 4'd9, 4'd0, 4'd15, 4'd4, 4'd2, 4'd6};
    offline_plan[7] = 20'($urandom_range(1, 999999));
    stale_plan[7]   = 4'($urandom_range(1, 9));
    for (int i = 0; i < 4; i++) pitch_pool[i] = $urandom;
    quota = RANDOM_BEATS / 8;
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(offline_plan[ph], stale_plan[ph]);
      start_live = live_beats;
      while (live_beats - start_live < quota) begin
        pick = $urandom_range(0, 99);
        p = ($urandom_range(0, 1) == 1) ? pitch_pool[$urandom_range(0, 3)] : $urandom;
        if (pick < 60) begin
          send_frame(($urandom_range(0, 11) == 0) ? 8'($urandom) : vlfr_pkg::HEADER_BYTE,
                     p, $urandom, 8'($urandom),
                     ($urandom_range(0, 11) == 0) ? 8'($urandom) : vlfr_pkg::TRAILER_BYTE,
                     ($urandom_range(0, 9) != 0), 5);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 4)) send_tick();
        end else if (pick < 90) begin
          // frame cut short; the next start flag restarts assembly
          send_beat(vlfr_pkg::ACT_BYTE, vlfr_pkg::HEADER_BYTE, 1'b1);
          repeat ($urandom_range(1, FRAME_LEN - 2))
            send_beat(vlfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(1, 5))
            send_beat(vlfr_pkg::ACT_BYTE, 8'($urandom), ($urandom_range(0, 4) == 0));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rx_pos       = 0;
    lat_pitch    = '0;
    lat_yaw      = '0;
    lat_status   = '0;
    link_up      = 1'b0;
    link_up_prev = 1'b0;
    miss_cnt     = 0;
    ring_wr      = 0;
    ring_pairs   = '0;
    for (int i = 0; i < 16; i++) rx_buf[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) pitch_ring[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_frame_fields();
    test_bad_frames();
    test_link_timeout();
    test_stale_history();
    test_random_traffic();

    // drain, then give the block time to show any stray result
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_due_q.size() != 0) begin
      $error("%0d expected results never arrived", status_due_q.size());
      fail_count++;
    end

    $display("Coverage: %0d input beats (%0d live), %0d results checked, %0d register settings",
             beats_sent, live_beats, results_seen, settings_used);
    $display("Coverage: %0d frames accepted, %0d link drops, %0d mismatches",
             frames_taken, link_drops, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
